// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Condition that must never be seen at a rising clock edge outside of reset.
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error(msg);

`endif

// ===== rtl/core/urs_pkg.sv =====
// ----------------------------------------------------------------------------
// urs_pkg
// Types and constants of the undo/redo stack pair.
// ----------------------------------------------------------------------------
package urs_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int VALUE_W    = 32;
    localparam int DEPTH_W    = 5;

    typedef logic [DATA_WIDTH-1:0] t_data;
    typedef logic [CNT_W-1:0]      t_count;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_PULL = 2'd1,
        OP_UNDO = 2'd2,
        OP_REDO = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_op                operation;
        logic [VALUE_W-1:0] push_value;
    } t_urs_in;

    typedef struct packed {
        logic [VALUE_W-1:0] result_value;
        logic               result_valid;
        t_status            status;
        logic [VALUE_W-1:0] top_value;
        logic               top_valid;
        logic [DEPTH_W-1:0] undo_depth;
        logic [DEPTH_W-1:0] redo_depth;
    } t_urs_out;

    // Per-cycle command to one stack; push and pop are never both set.
    typedef struct packed {
        logic push;
        logic pop;
    } t_stk_ctl;

    // What one stack shows to the operation logic.
    typedef struct packed {
        t_count count;
        t_data  top;
        t_data  second;
    } t_stk_view;

endpackage

// ===== rtl/core/urs_ram.sv =====
// ----------------------------------------------------------------------------
// urs_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module urs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read returns the contents before a write at the same edge.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/urs_stack.sv =====
// ----------------------------------------------------------------------------
// urs_stack
// Bounded LIFO: top entry and count in registers, lower entries in a RAM.
// The entry just below the top is always ready, from the RAM read port or
// from a bypass register right after a push.
// ----------------------------------------------------------------------------
module urs_stack (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  urs_pkg::t_stk_ctl   i_ctl,
    input  urs_pkg::t_data      i_data,
    output urs_pkg::t_stk_view  o_view
);

    urs_pkg::t_count r_count;
    urs_pkg::t_count n_count;
    urs_pkg::t_count rd_ptr;
    urs_pkg::t_count wr_ptr;
    urs_pkg::t_data  r_top;
    urs_pkg::t_data  n_top;
    urs_pkg::t_data  r_byp;
    logic            r_sel_byp;
    urs_pkg::t_data  ram_rdata;
    urs_pkg::t_data  second;
    logic            ram_we;

    assign second = r_sel_byp ? r_byp : ram_rdata;

    always_comb begin
        n_count = r_count;
        n_top   = r_top;
        if (i_ctl.push) begin
            n_count = r_count + urs_pkg::t_count'(1);
            n_top   = i_data;
        end else if (i_ctl.pop) begin
            n_count = r_count - urs_pkg::t_count'(1);
            n_top   = second;
        end
    end

    // The old top drops into the RAM on a push; the read port follows the
    // entry below the new top.
    assign ram_we = i_ctl.push && (r_count != '0);
    assign wr_ptr = r_count - urs_pkg::t_count'(1);
    assign rd_ptr = n_count - urs_pkg::t_count'(2);

    urs_ram #(
        .WIDTH (urs_pkg::DATA_WIDTH),
        .DEPTH (urs_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (wr_ptr[urs_pkg::ADDR_W-1:0]),
        .i_wdata (r_top),
        .i_raddr (rd_ptr[urs_pkg::ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_sel_byp <= 1'b0;
        end else begin
            r_count   <= n_count;
            // The RAM read of the entry being written now would return stale
            // data, so the old top is held here and selected right after the push.
            r_sel_byp <= i_ctl.push;
        end
        r_top <= n_top;
        if (i_ctl.push) begin
            r_byp <= r_top;
        end
    end

    assign o_view.count  = r_count;
    assign o_view.top    = r_top;
    assign o_view.second = second;

endmodule

// ===== rtl/core/undo_redo_stack_pair.sv =====
// ----------------------------------------------------------------------------
// undo_redo_stack_pair
// Undo stack and redo stack of bounded depth with push, pull, undo and redo.
// ----------------------------------------------------------------------------
// Each accepted item carries one operation and yields exactly one result item,
// which reports the popped word or new undo top, a status, the undo top after
// the operation and both depths. One item is accepted every cycle while the
// skid register is empty; its result goes to the output register, or to the
// skid register while a result waits, so items keep flowing. Each item makes
// a single update of the two stacks: each stack keeps its top in a register and
// the entry below it ready at the registered read port of its RAM. Refused
// operations (empty, too shallow or full) leave both stacks unchanged.
module undo_redo_stack_pair (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  urs_pkg::t_urs_in  i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output urs_pkg::t_urs_out o_out_item
);

    `include "assert_macros.svh"

    logic               in_acc;
    logic               out_take;
    urs_pkg::t_stk_view u_view;
    urs_pkg::t_stk_view r_view;
    urs_pkg::t_stk_ctl  u_ctl;
    urs_pkg::t_stk_ctl  r_ctl;
    urs_pkg::t_data     u_data;
    urs_pkg::t_data     r_data;
    urs_pkg::t_data     push_word;
    urs_pkg::t_data     res_word;
    logic               res_ok;
    urs_pkg::t_status   status;
    urs_pkg::t_count    nu_count;
    urs_pkg::t_count    nr_count;
    urs_pkg::t_data     nu_top;
    urs_pkg::t_urs_out  result;

    urs_pkg::t_urs_out  r_out;
    logic               r_out_valid;
    urs_pkg::t_urs_out  r_skid;
    logic               r_skid_valid;

    assign o_in_ready = !r_skid_valid;
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_take   = r_out_valid && i_out_ready;
    assign push_word  = urs_pkg::DATA_WIDTH'(i_in_item.push_value);

    always_comb begin
        u_ctl    = '0;
        r_ctl    = '0;
        u_data   = push_word;
        r_data   = u_view.top;
        res_word = '0;
        res_ok   = 1'b0;
        status   = urs_pkg::ST_DONE;
        case (i_in_item.operation)
            urs_pkg::OP_PUSH: begin
                if (u_view.count == urs_pkg::t_count'(urs_pkg::DEPTH)) begin
                    status = urs_pkg::ST_FULL;
                end else begin
                    u_ctl.push = 1'b1;
                end
            end
            urs_pkg::OP_PULL: begin
                if (u_view.count == '0) begin
                    status = urs_pkg::ST_EMPTY;
                end else begin
                    u_ctl.pop = 1'b1;
                    res_word  = u_view.top;
                    res_ok    = 1'b1;
                end
            end
            urs_pkg::OP_UNDO: begin
                if (u_view.count < urs_pkg::t_count'(2)) begin
                    status = urs_pkg::ST_EMPTY;
                end else if (r_view.count == urs_pkg::t_count'(urs_pkg::DEPTH)) begin
                    status = urs_pkg::ST_FULL;
                end else begin
                    u_ctl.pop  = 1'b1;
                    r_ctl.push = 1'b1;
                    res_word   = u_view.second;
                    res_ok     = 1'b1;
                end
            end
            urs_pkg::OP_REDO: begin
                if (r_view.count == '0) begin
                    status = urs_pkg::ST_EMPTY;
                end else if (u_view.count == urs_pkg::t_count'(urs_pkg::DEPTH)) begin
                    status = urs_pkg::ST_FULL;
                end else begin
                    r_ctl.pop  = 1'b1;
                    u_ctl.push = 1'b1;
                    u_data     = r_view.top;
                    res_word   = r_view.top;
                    res_ok     = 1'b1;
                end
            end
            default: begin
                status = urs_pkg::ST_EMPTY;
            end
        endcase

        // Nothing moves unless the item is actually taken.
        if (!in_acc) begin
            u_ctl = '0;
            r_ctl = '0;
        end
    end

    // Undo stack view and redo stack depth after the operation, for the peek and depth fields.
    always_comb begin
        nu_count = u_view.count;
        nu_top   = u_view.top;
        nr_count = r_view.count;
        if (u_ctl.push) begin
            nu_count = u_view.count + urs_pkg::t_count'(1);
            nu_top   = u_data;
        end else if (u_ctl.pop) begin
            nu_count = u_view.count - urs_pkg::t_count'(1);
            nu_top   = u_view.second;
        end
        if (r_ctl.push) begin
            nr_count = r_view.count + urs_pkg::t_count'(1);
        end else if (r_ctl.pop) begin
            nr_count = r_view.count - urs_pkg::t_count'(1);
        end
    end

    always_comb begin
        result.result_value = urs_pkg::VALUE_W'(res_word);
        result.result_valid = res_ok;
        result.status       = status;
        result.top_valid    = (nu_count != '0);
        result.top_value    = (nu_count != '0) ? urs_pkg::VALUE_W'(nu_top) : '0;
        result.undo_depth   = urs_pkg::DEPTH_W'(nu_count);
        result.redo_depth   = urs_pkg::DEPTH_W'(nr_count);
    end

    urs_stack u_undo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (u_ctl),
        .i_data  (u_data),
        .o_view  (u_view)
    );

    urs_stack u_redo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_ctl),
        .i_data  (r_data),
        .o_view  (r_view)
    );

    // Output register with a skid register behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (in_acc) begin
            if (!r_out_valid || out_take) begin
                r_out       <= result;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= result;
                r_skid_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `ASSERT_NEVER(a_skid_needs_out, r_skid_valid && !r_out_valid,
        "skid register holds an item while the output register is empty")
    `ASSERT_NEVER(a_undo_bound, u_view.count > urs_pkg::t_count'(urs_pkg::DEPTH),
        "undo stack depth above its bound")
    `ASSERT_CLK(a_refused_stable,
        in_acc && (status != urs_pkg::ST_DONE) |=> $stable(u_view.count) && $stable(r_view.count),
        "refused item changed a stack depth")
    `ASSERT_CLK(a_move_keeps_total,
        in_acc && (status == urs_pkg::ST_DONE) &&
        ((i_in_item.operation == urs_pkg::OP_UNDO) || (i_in_item.operation == urs_pkg::OP_REDO))
        |=> (u_view.count + r_view.count) == $past(u_view.count + r_view.count),
        "undo or redo changed the total number of entries")

endmodule

// ===== dv/urs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urs_checker
// Watches both channels of the undo/redo stack pair, keeps its own copy of
// the two stacks, predicts each result item and compares it field by field.
// ----------------------------------------------------------------------------
module urs_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  urs_pkg::t_urs_in  i_in_item,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  urs_pkg::t_urs_out i_out_item,
    output int                o_err_count,
    output int                o_pending
);

    urs_pkg::t_data    undo_mem [urs_pkg::DEPTH];
    urs_pkg::t_data    redo_mem [urs_pkg::DEPTH];
    int                undo_cnt;
    int                redo_cnt;
    urs_pkg::t_urs_out expected_results [$];

    initial begin
        o_err_count = 0;
        undo_cnt    = 0;
        redo_cnt    = 0;
    end

    assign o_pending = expected_results.size();

    // Applies one operation to the shadow stacks and returns its result item.
    function automatic urs_pkg::t_urs_out apply_stack_op(input urs_pkg::t_urs_in item);
        urs_pkg::t_urs_out res;
        urs_pkg::t_data    word;
        logic              moved;
        res      = '0;
        res.status = urs_pkg::ST_DONE;
        word     = item.push_value[urs_pkg::DATA_WIDTH-1:0];
        moved    = 1'b0;
        case (item.operation)
            urs_pkg::OP_PUSH: begin
                if (undo_cnt >= urs_pkg::DEPTH) begin
                    res.status = urs_pkg::ST_FULL;
                end else begin
                    undo_mem[undo_cnt] = word;
                    undo_cnt++;
                end
            end
            urs_pkg::OP_PULL: begin
                if (undo_cnt == 0) begin
                    res.status = urs_pkg::ST_EMPTY;
                end else begin
                    undo_cnt--;
                    res.result_value = urs_pkg::VALUE_W'(undo_mem[undo_cnt]);
                    res.result_valid = 1'b1;
                end
            end
            urs_pkg::OP_UNDO: begin
                if (undo_cnt <= 1) begin
                    res.status = urs_pkg::ST_EMPTY;
                end else if (redo_cnt >= urs_pkg::DEPTH) begin
                    res.status = urs_pkg::ST_FULL;
                end else begin
                    undo_cnt--;
                    redo_mem[redo_cnt] = undo_mem[undo_cnt];
                    redo_cnt++;
                    moved = 1'b1;
                end
            end
            default: begin
                if (redo_cnt == 0) begin
                    res.status = urs_pkg::ST_EMPTY;
                end else if (undo_cnt >= urs_pkg::DEPTH) begin
                    res.status = urs_pkg::ST_FULL;
                end else begin
                    redo_cnt--;
                    undo_mem[undo_cnt] = redo_mem[redo_cnt];
                    undo_cnt++;
                    moved = 1'b1;
                end
            end
        endcase
        if (undo_cnt > 0) begin
            res.top_value = urs_pkg::VALUE_W'(undo_mem[undo_cnt-1]);
            res.top_valid = 1'b1;
            if (moved) begin
                res.result_value = res.top_value;
                res.result_valid = 1'b1;
            end
        end
        res.undo_depth = urs_pkg::DEPTH_W'(undo_cnt);
        res.redo_depth = urs_pkg::DEPTH_W'(redo_cnt);
        return res;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        o_err_count++;
        $display("%0t: %s mismatch: got %h, expected %h", $time, field, got, want);
    endtask

    always @(posedge i_clk) begin
        urs_pkg::t_urs_out want;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result item", 32'(i_out_item.status), '0);
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_item.result_value !== want.result_value)
                        report_mismatch("result_value", i_out_item.result_value,
                                        want.result_value);
                    if (i_out_item.result_valid !== want.result_valid)
                        report_mismatch("result_valid", 32'(i_out_item.result_valid),
                                        32'(want.result_valid));
                    if (i_out_item.status !== want.status)
                        report_mismatch("status", 32'(i_out_item.status), 32'(want.status));
                    if (i_out_item.top_value !== want.top_value)
                        report_mismatch("top_value", i_out_item.top_value, want.top_value);
                    if (i_out_item.top_valid !== want.top_valid)
                        report_mismatch("top_valid", 32'(i_out_item.top_valid),
                                        32'(want.top_valid));
                    if (i_out_item.undo_depth !== want.undo_depth)
                        report_mismatch("undo_depth", 32'(i_out_item.undo_depth),
                                        32'(want.undo_depth));
                    if (i_out_item.redo_depth !== want.redo_depth)
                        report_mismatch("redo_depth", 32'(i_out_item.redo_depth),
                                        32'(want.redo_depth));
                end
            end
            if (i_in_valid && i_in_ready)
                expected_results.push_back(apply_stack_op(i_in_item));
        end
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives push, pull, undo and redo items into the undo/redo stack pair,
// first a directed walk through the empty, shallow and refused cases, then
// random phases biased toward filling or draining the stacks, with random
// stalls on both channels and long receiver hold-offs.
// ----------------------------------------------------------------------------
module testbench;

    localparam int RANDOM_ITEMS   = 630;
    localparam int QUIET_TAIL     = 60;
    localparam int HOLD_CYCLES    = 60;
    localparam int WATCHDOG_LIMIT = 1000;

    typedef enum int {
        MIX_FILL,
        MIX_UNDO,
        MIX_DRAIN,
        MIX_EVEN
    } t_mix;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    urs_pkg::t_urs_in  in_item   = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    urs_pkg::t_urs_out out_item;

    int       err_count;
    int       pending;
    int       results_seen = 0;
    int       stall_cycles = 0;
    int       hold_mark    = 40;
    bit       quiet        = 1'b0;

    // Empty and shallow refusals, extreme words, and a push after an undo.
    urs_pkg::t_urs_in directed_ops [23] = '{
        '{urs_pkg::OP_PULL, 32'h0000_0000}, '{urs_pkg::OP_UNDO, 32'hFFFF_FFFF},
        '{urs_pkg::OP_REDO, 32'h1234_5678}, '{urs_pkg::OP_PUSH, 32'h0000_0000},
        '{urs_pkg::OP_UNDO, 32'h0000_0000}, '{urs_pkg::OP_PUSH, 32'hFFFF_FFFF},
        '{urs_pkg::OP_PUSH, 32'h8000_0001}, '{urs_pkg::OP_UNDO, 32'h0000_0000},
        '{urs_pkg::OP_UNDO, 32'h0000_0000}, '{urs_pkg::OP_UNDO, 32'h0000_0000},
        '{urs_pkg::OP_REDO, 32'h0000_0000}, '{urs_pkg::OP_REDO, 32'h0000_0000},
        '{urs_pkg::OP_REDO, 32'h0000_0000}, '{urs_pkg::OP_PUSH, 32'h5555_5555},
        '{urs_pkg::OP_PUSH, 32'hAAAA_AAAA}, '{urs_pkg::OP_UNDO, 32'h0000_0000},
        '{urs_pkg::OP_PUSH, 32'h0000_0001}, '{urs_pkg::OP_PULL, 32'h0000_0000},
        '{urs_pkg::OP_PULL, 32'h0000_0000}, '{urs_pkg::OP_PULL, 32'h0000_0000},
        '{urs_pkg::OP_PULL, 32'h0000_0000}, '{urs_pkg::OP_PULL, 32'h0000_0000},
        '{urs_pkg::OP_PULL, 32'h0000_0000}
    };

    undo_redo_stack_pair u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    urs_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_item  (out_item),
        .o_err_count (err_count),
        .o_pending   (pending)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        if (out_valid && out_ready)
            results_seen <= results_seen + 1;
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Result side: ready bursts, stall bursts, and two long hold-offs that
    // let the block fill up and push back on its input.
    initial begin
        int n;
        wait (rst_n);
        forever begin
            if (results_seen >= hold_mark) begin
                hold_mark = (hold_mark < 300) ? 350 : 32'h7FFF_FFFF;
                out_ready <= 1'b0;
                for (int c = 0; c < HOLD_CYCLES; c++)
                    @(negedge clk);
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 8);
                out_ready <= 1'b0;
                repeat (n) @(negedge clk);
            end else begin
                n = $urandom_range(1, 8);
                out_ready <= 1'b1;
                repeat (n) @(negedge clk);
            end
        end
    end

    task automatic offer_item(input urs_pkg::t_urs_in item);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Each mix leans toward one direction so that both stacks reach full
    // and empty many times over the run.
    function automatic urs_pkg::t_urs_in make_item(input t_mix mix);
        urs_pkg::t_urs_in item;
        int               roll;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:  item.operation = (roll < 55) ? urs_pkg::OP_PUSH :
                                        (roll < 80) ? urs_pkg::OP_REDO :
                                        (roll < 90) ? urs_pkg::OP_UNDO : urs_pkg::OP_PULL;
            MIX_UNDO:  item.operation = (roll < 55) ? urs_pkg::OP_UNDO :
                                        (roll < 80) ? urs_pkg::OP_PUSH :
                                        (roll < 90) ? urs_pkg::OP_REDO : urs_pkg::OP_PULL;
            MIX_DRAIN: item.operation = (roll < 50) ? urs_pkg::OP_PULL :
                                        (roll < 70) ? urs_pkg::OP_UNDO :
                                        (roll < 90) ? urs_pkg::OP_REDO : urs_pkg::OP_PUSH;
            default:   item.operation = urs_pkg::t_op'($urandom_range(0, 3));
        endcase
        roll = $urandom_range(0, 15);
        item.push_value = (roll == 0) ? 32'h0000_0000 :
                          (roll == 1) ? 32'hFFFF_FFFF : $urandom;
        return item;
    endfunction

    initial begin
        t_mix mix;
        int   mix_left;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_ops[k])
            offer_item(directed_ops[k]);

        mix_left = 0;
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (mix_left == 0) begin
                mix      = t_mix'($urandom_range(0, 3));
                mix_left = $urandom_range(15, 40);
            end
            mix_left--;
            if (k == RANDOM_ITEMS - QUIET_TAIL)
                quiet = 1'b1;
            offer_item(make_item(mix));
        end
        in_valid <= 1'b0;

        wait (pending == 0);
        repeat (4) @(posedge clk);
        if (err_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/urs_pkg.sv
rtl/core/urs_ram.sv
rtl/core/urs_stack.sv
rtl/core/undo_redo_stack_pair.sv
dv/urs_checker.sv
dv/testbench.sv
